// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the camera ray generator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ASSERT_IMPLIES(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hdl/crg_pkg.sv =====
// Types, constants and helpers of the camera ray generator.
package crg_pkg;

	localparam int PIXEL_INDEX_BITS_DEF     = 12;
	localparam int RESULT_FRACTION_BITS_DEF = 16;

	localparam int VEC_W     = 63;
	localparam int COMP_W    = 21;
	localparam int PS_W      = 24;
	localparam int RES_W     = 13;
	localparam int AP_W      = 16;
	localparam int JIT_W     = 16;
	localparam int LENS_W    = 16;
	localparam int OUT_W     = 32;
	localparam int CFG_IDX_W = 3;
	localparam int LENS_PROD_W = LENS_W + AP_W + 1;
	localparam int SHIFT_W   = LENS_PROD_W - 3;
	localparam int LO_W      = 20;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CAMERA_POSITION = 3'd0,
		REG_LOOK_VECTOR     = 3'd1,
		REG_UP_VECTOR       = 3'd2,
		REG_RIGHT_VECTOR    = 3'd3,
		REG_PIXEL_SIZE      = 3'd4,
		REG_X_RESOLUTION    = 3'd5,
		REG_Y_RESOLUTION    = 3'd6,
		REG_APERTURE_RADIUS = 3'd7
	} crg_reg_t;

	typedef struct packed {
		logic [VEC_W-1:0] position;
		logic [VEC_W-1:0] look;
		logic [VEC_W-1:0] up;
		logic [VEC_W-1:0] right;
		logic [PS_W-1:0]  pixel_size;
		logic [RES_W-1:0] x_res;
		logic [RES_W-1:0] y_res;
		logic [AP_W-1:0]  aperture;
	} crg_cfg_t;

	function automatic logic signed [COMP_W-1:0] vec_comp(input logic [VEC_W-1:0] v,
		input int unsigned k);
		return v[VEC_W-1-COMP_W*k -: COMP_W];
	endfunction

endpackage

// ===== hdl/crg_regs.sv =====
// Configuration register file of the camera ray generator.
module crg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write,
	input  logic [crg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [crg_pkg::VEC_W-1:0]      cfg_data,
	output crg_pkg::crg_cfg_t              cfg
);

	crg_pkg::crg_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.position   <= crg_pkg::VEC_W'(64'd10240);
			cfg_q.look       <= crg_pkg::VEC_W'(64'd2096128);
			cfg_q.up         <= crg_pkg::VEC_W'(64'd2147483648);
			cfg_q.right      <= crg_pkg::VEC_W'(64'd4503599627370496);
			cfg_q.pixel_size <= crg_pkg::PS_W'(58254);
			cfg_q.x_res      <= crg_pkg::RES_W'(512);
			cfg_q.y_res      <= crg_pkg::RES_W'(288);
			cfg_q.aperture   <= '0;
		end else if (cfg_write) begin
			unique case (crg_pkg::crg_reg_t'(cfg_index))
				crg_pkg::REG_CAMERA_POSITION: cfg_q.position <= cfg_data;
				crg_pkg::REG_LOOK_VECTOR:     cfg_q.look     <= cfg_data;
				crg_pkg::REG_UP_VECTOR:       cfg_q.up       <= cfg_data;
				crg_pkg::REG_RIGHT_VECTOR:    cfg_q.right    <= cfg_data;
				crg_pkg::REG_PIXEL_SIZE:      cfg_q.pixel_size <= cfg_data[crg_pkg::PS_W-1:0];
				crg_pkg::REG_X_RESOLUTION:    cfg_q.x_res    <= cfg_data[crg_pkg::RES_W-1:0];
				crg_pkg::REG_Y_RESOLUTION:    cfg_q.y_res    <= cfg_data[crg_pkg::RES_W-1:0];
				crg_pkg::REG_APERTURE_RADIUS: cfg_q.aperture <= cfg_data[crg_pkg::AP_W-1:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hdl/crg_screen.sv =====
// Screen offset and lens shift stages (stages one to three).
module crg_screen #(
	parameter int PIX_W = crg_pkg::PIXEL_INDEX_BITS_DEF,
	parameter int OFF_W = ((PIX_W + 16 > 28) ? PIX_W + 16 : 28) + 2,
	parameter int PRODW = OFF_W + crg_pkg::PS_W + 1,
	parameter int U_W   = PRODW - 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                accept,
	input  logic [PIX_W-1:0]                    pixel_column,
	input  logic [PIX_W-1:0]                    pixel_row,
	input  logic [crg_pkg::JIT_W-1:0]           jitter_x,
	input  logic [crg_pkg::JIT_W-1:0]           jitter_y,
	input  logic signed [crg_pkg::LENS_W-1:0]   lens_x,
	input  logic signed [crg_pkg::LENS_W-1:0]   lens_y,
	input  crg_pkg::crg_cfg_t                   cfg,
	output logic                                valid_s3,
	output logic signed [U_W-1:0]               u_s3,
	output logic signed [U_W-1:0]               v_s3,
	output logic signed [crg_pkg::SHIFT_W-1:0]  sx_s3,
	output logic signed [crg_pkg::SHIFT_W-1:0]  sy_s3
);

	localparam logic signed [PRODW-1:0] HALF_UV = PRODW'(1) <<< 15;
	localparam logic signed [crg_pkg::LENS_PROD_W-1:0] HALF_LENS =
		crg_pkg::LENS_PROD_W'(4);

	logic                                   valid_s1, valid_s2;
	logic signed [OFF_W-1:0]                off_u, off_v, off_u_s1, off_v_s1;
	logic signed [crg_pkg::LENS_W-1:0]      lx_s1, ly_s1;
	logic signed [PRODW-1:0]                pu_s2, pv_s2, ru, rv;
	logic signed [crg_pkg::LENS_PROD_W-1:0] plx_s2, ply_s2, rlx, rly;

	assign off_u = OFF_W'({pixel_column, 16'b0}) - OFF_W'({cfg.x_res, 15'b0})
		+ OFF_W'(jitter_x);
	assign off_v = OFF_W'({cfg.y_res, 15'b0}) - OFF_W'({pixel_row, 16'b0})
		- OFF_W'(jitter_y);

	assign ru  = pu_s2 + HALF_UV;
	assign rv  = pv_s2 + HALF_UV;
	assign rlx = plx_s2 + HALF_LENS;
	assign rly = ply_s2 + HALF_LENS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		off_u_s1 <= off_u;
		off_v_s1 <= off_v;
		lx_s1    <= lens_x;
		ly_s1    <= lens_y;
		pu_s2    <= off_u_s1 * $signed({1'b0, cfg.pixel_size});
		pv_s2    <= off_v_s1 * $signed({1'b0, cfg.pixel_size});
		plx_s2   <= lx_s1 * $signed({1'b0, cfg.aperture});
		ply_s2   <= ly_s1 * $signed({1'b0, cfg.aperture});
		u_s3     <= ru[PRODW-1:16];
		v_s3     <= rv[PRODW-1:16];
		sx_s3    <= rlx[crg_pkg::LENS_PROD_W-1:3];
		sy_s3    <= rly[crg_pkg::LENS_PROD_W-1:3];
	end

endmodule

// ===== hdl/crg_axis.sv =====
// One vector component: products, sums, rounding and saturation (stages four to seven).
module crg_axis #(
	parameter int U_W = 39,
	parameter int RFB = crg_pkg::RESULT_FRACTION_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 valid_in,
	input  logic signed [U_W-1:0]                u,
	input  logic signed [U_W-1:0]                v,
	input  logic signed [crg_pkg::SHIFT_W-1:0]   sx,
	input  logic signed [crg_pkg::SHIFT_W-1:0]   sy,
	input  logic signed [crg_pkg::COMP_W-1:0]    right_c,
	input  logic signed [crg_pkg::COMP_W-1:0]    up_c,
	input  logic signed [crg_pkg::COMP_W-1:0]    position_c,
	input  logic signed [crg_pkg::COMP_W-1:0]    look_c,
	output logic                                 valid_s7,
	output logic signed [crg_pkg::OUT_W-1:0]     origin_s7,
	output logic signed [crg_pkg::OUT_W-1:0]     direction_s7
);

	localparam int LO_W   = crg_pkg::LO_W;
	localparam int HI_W   = U_W - LO_W;
	localparam int PLO_W  = 2 * crg_pkg::COMP_W;
	localparam int PHI_W  = crg_pkg::COMP_W + HI_W;
	localparam int PS_W2  = crg_pkg::COMP_W + crg_pkg::SHIFT_W;
	localparam int SUM_W  = U_W + crg_pkg::COMP_W + 4;
	localparam int RS     = 34 - RFB;
	localparam int RW     = SUM_W - RS;
	localparam logic signed [SUM_W-1:0] HALF = SUM_W'(64'd1 << (RS - 1));
	localparam logic signed [RW-1:0] MAXV = RW'(32'sh7FFF_FFFF);
	localparam logic signed [RW-1:0] MINV = RW'(32'sh8000_0000);

	logic                     valid_s4, valid_s5, valid_s6;
	logic signed [PLO_W-1:0]  ru_lo_s4, uv_lo_s4;
	logic signed [PHI_W-1:0]  ru_hi_s4, uv_hi_s4;
	logic signed [PS_W2-1:0]  rs_s4, us_s4;
	logic signed [SUM_W-1:0]  ru_s5, uv_s5, shift_s5, org_s6, dir_s6;
	logic signed [SUM_W-1:0]  org_r, dir_r;
	logic signed [RW-1:0]     org_t, dir_t;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else begin
			valid_s4 <= valid_in;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
		end
	end

	assign org_r = org_s6 + HALF;
	assign dir_r = dir_s6 + HALF;
	assign org_t = org_r[SUM_W-1:RS];
	assign dir_t = dir_r[SUM_W-1:RS];

	always_ff @(posedge clk) begin
		ru_lo_s4 <= right_c * $signed({1'b0, u[LO_W-1:0]});
		ru_hi_s4 <= right_c * $signed(u[U_W-1:LO_W]);
		uv_lo_s4 <= up_c * $signed({1'b0, v[LO_W-1:0]});
		uv_hi_s4 <= up_c * $signed(v[U_W-1:LO_W]);
		rs_s4    <= right_c * sx;
		us_s4    <= up_c * sy;
		ru_s5    <= (SUM_W'(ru_hi_s4) <<< LO_W) + SUM_W'(ru_lo_s4);
		uv_s5    <= (SUM_W'(uv_hi_s4) <<< LO_W) + SUM_W'(uv_lo_s4);
		shift_s5 <= SUM_W'(rs_s4) + SUM_W'(us_s4);
		org_s6   <= (SUM_W'(position_c) <<< 24) + shift_s5;
		dir_s6   <= (SUM_W'(look_c) <<< 24) + ru_s5 + uv_s5 - shift_s5;
		if (org_t > MAXV) begin
			origin_s7 <= crg_pkg::OUT_W'(MAXV);
		end else if (org_t < MINV) begin
			origin_s7 <= crg_pkg::OUT_W'(MINV);
		end else begin
			origin_s7 <= crg_pkg::OUT_W'(org_t);
		end
		if (dir_t > MAXV) begin
			direction_s7 <= crg_pkg::OUT_W'(MAXV);
		end else if (dir_t < MINV) begin
			direction_s7 <= crg_pkg::OUT_W'(MINV);
		end else begin
			direction_s7 <= crg_pkg::OUT_W'(dir_t);
		end
	end

endmodule

// ===== hdl/camera_ray_generator.sv =====
// Top level of the thin-lens camera ray generator.
// Throughput: one word per cycle while busy is low; a seven-stage pipeline with no stall path.
// The receiver cannot stall, so every accepted word passes stages s1 to s7 and raises done.
// Reset clears the pipeline valid bits and loads the register defaults.
// Busy is high while reset is asserted and in the first cycle after reset is released.
module camera_ray_generator #(
	parameter int PIXEL_INDEX_BITS     = crg_pkg::PIXEL_INDEX_BITS_DEF,
	parameter int RESULT_FRACTION_BITS = crg_pkg::RESULT_FRACTION_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [PIXEL_INDEX_BITS-1:0]         pixel_column,
	input  logic [PIXEL_INDEX_BITS-1:0]         pixel_row,
	input  logic [crg_pkg::JIT_W-1:0]           jitter_x,
	input  logic [crg_pkg::JIT_W-1:0]           jitter_y,
	input  logic signed [crg_pkg::LENS_W-1:0]   lens_x,
	input  logic signed [crg_pkg::LENS_W-1:0]   lens_y,
	input  logic                                cfg_write,
	input  logic [crg_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [crg_pkg::VEC_W-1:0]           cfg_data,
	output logic                                done,
	output logic signed [crg_pkg::OUT_W-1:0]    origin_x,
	output logic signed [crg_pkg::OUT_W-1:0]    origin_y,
	output logic signed [crg_pkg::OUT_W-1:0]    origin_z,
	output logic signed [crg_pkg::OUT_W-1:0]    direction_x,
	output logic signed [crg_pkg::OUT_W-1:0]    direction_y,
	output logic signed [crg_pkg::OUT_W-1:0]    direction_z
);

`include "assert_macros.svh"

	localparam int OFF_W = ((PIXEL_INDEX_BITS + 16 > 28) ? PIXEL_INDEX_BITS + 16 : 28) + 2;
	localparam int PRODW = OFF_W + crg_pkg::PS_W + 1;
	localparam int U_W   = PRODW - 16;

	crg_pkg::crg_cfg_t                  cfg;
	logic                               busy_q;
	logic                               accept;
	logic                               valid_s3;
	logic signed [U_W-1:0]              u_s3, v_s3;
	logic signed [crg_pkg::SHIFT_W-1:0] sx_s3, sy_s3;
	logic                               vx_s7, vy_s7, vz_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	assign busy   = busy_q;
	assign accept = start && !busy_q;
	assign done   = vx_s7 && vy_s7 && vz_s7;

	crg_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	crg_screen #(
		.PIX_W (PIXEL_INDEX_BITS),
		.OFF_W (OFF_W),
		.PRODW (PRODW),
		.U_W   (U_W)
	) u_screen (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.pixel_column (pixel_column),
		.pixel_row    (pixel_row),
		.jitter_x     (jitter_x),
		.jitter_y     (jitter_y),
		.lens_x       (lens_x),
		.lens_y       (lens_y),
		.cfg          (cfg),
		.valid_s3     (valid_s3),
		.u_s3         (u_s3),
		.v_s3         (v_s3),
		.sx_s3        (sx_s3),
		.sy_s3        (sy_s3)
	);

	crg_axis #(.U_W(U_W), .RFB(RESULT_FRACTION_BITS)) u_axis_x (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid_in     (valid_s3),
		.u            (u_s3),
		.v            (v_s3),
		.sx           (sx_s3),
		.sy           (sy_s3),
		.right_c      (crg_pkg::vec_comp(cfg.right, 0)),
		.up_c         (crg_pkg::vec_comp(cfg.up, 0)),
		.position_c   (crg_pkg::vec_comp(cfg.position, 0)),
		.look_c       (crg_pkg::vec_comp(cfg.look, 0)),
		.valid_s7     (vx_s7),
		.origin_s7    (origin_x),
		.direction_s7 (direction_x)
	);

	crg_axis #(.U_W(U_W), .RFB(RESULT_FRACTION_BITS)) u_axis_y (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid_in     (valid_s3),
		.u            (u_s3),
		.v            (v_s3),
		.sx           (sx_s3),
		.sy           (sy_s3),
		.right_c      (crg_pkg::vec_comp(cfg.right, 1)),
		.up_c         (crg_pkg::vec_comp(cfg.up, 1)),
		.position_c   (crg_pkg::vec_comp(cfg.position, 1)),
		.look_c       (crg_pkg::vec_comp(cfg.look, 1)),
		.valid_s7     (vy_s7),
		.origin_s7    (origin_y),
		.direction_s7 (direction_y)
	);

	crg_axis #(.U_W(U_W), .RFB(RESULT_FRACTION_BITS)) u_axis_z (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid_in     (valid_s3),
		.u            (u_s3),
		.v            (v_s3),
		.sx           (sx_s3),
		.sy           (sy_s3),
		.right_c      (crg_pkg::vec_comp(cfg.right, 2)),
		.up_c         (crg_pkg::vec_comp(cfg.up, 2)),
		.position_c   (crg_pkg::vec_comp(cfg.position, 2)),
		.look_c       (crg_pkg::vec_comp(cfg.look, 2)),
		.valid_s7     (vz_s7),
		.origin_s7    (origin_z),
		.direction_s7 (direction_z)
	);

	// Every done traces back to an accepted word, and no word leaves while busy.
	`ASSERT_IMPLIES(a_done_after_accept, done, $past(accept, 7), "done without an accepted word")
	`ASSERT_IMPLIES(a_lanes_agree, vx_s7 || vy_s7 || vz_s7, done, "component lanes out of step")
	`ASSERT_IMPLIES(a_no_done_busy, busy, !done, "done raised while busy")
	`ASSERT_NEXT(a_busy_stays_low, !busy, !busy, "busy rose after reset")

endmodule
